// ----- rtl/core/erd_pkg.sv -----
`timescale 1ns / 1ps

package erd_pkg;

  // Record layout and timestamp constants.
  localparam int unsigned RecordBytes = 5;
  localparam int unsigned TsWidth     = 23;
  localparam logic [7:0]  MarkerY     = 8'd240;
  localparam logic [31:0] OffsetStep  = 32'd1 << TsWidth;
  localparam logic [7:0]  SensorReset = 8'd34;

  // Configuration register indexes.
  localparam logic RegSensorWidth  = 1'b0;
  localparam logic RegSensorHeight = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_EVENT     = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_OFFSET_OV = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } status_e;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    status_e     status;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        polarity;
    logic [31:0] event_time;
  } out_item_t;

  // Outcome of evaluating a complete record.
  typedef struct packed {
    logic marker;     // record is an overflow marker
    logic emit;       // record produces a result
    logic error;      // result is an error, decoding stops until end of file
  } rec_ctrl_t;

endpackage

// ----- rtl/core/event_record_decoder.sv -----
`timescale 1ns / 1ps
// Output: the result is registered, and it appears on the output register in the cycle after the byte that completes
// the record (or ends the file early) is accepted.
// Throughput: one byte per cycle; the output register lets a new byte in while the held
// result is being taken, and input stalls only while a result waits and out_ready_i is low.
// Reset: asynchronous, active low; clears the decode state and output valid, and sets both
// sensor dimensions to 34. Held record bytes are not reset.

module event_record_decoder import erd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [7:0]  sensor_width_q, sensor_height_q;
  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  held_q [4];
  logic [31:0] time_offset_q, time_offset_d;
  logic        error_q, error_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        in_fire;
  logic        hold_byte;
  rec_ctrl_t   rec_ctrl;
  out_item_t   rec_result;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign hold_byte   = in_fire && !error_q && (byte_pos_q != 3'(RecordBytes - 1));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_width_q  <= SensorReset;
      sensor_height_q <= SensorReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSensorWidth:  sensor_width_q  <= cfg_data_i;
        RegSensorHeight: sensor_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Record evaluation on the fifth byte.
  erd_eval u_eval (
    .x_i            (held_q[0]),
    .y_i            (held_q[1]),
    .b2_i           (held_q[2]),
    .b3_i           (held_q[3]),
    .b4_i           (in_item_i.data_byte),
    .time_offset_i  (time_offset_q),
    .sensor_width_i (sensor_width_q),
    .sensor_height_i(sensor_height_q),
    .ctrl_o         (rec_ctrl),
    .result_o       (rec_result)
  );

  // Decode state and output register next values.
  always_comb begin
    byte_pos_d    = byte_pos_q;
    time_offset_d = time_offset_q;
    error_d       = error_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    if (in_fire && !error_q) begin
      if (byte_pos_q != 3'(RecordBytes - 1)) begin
        byte_pos_d = byte_pos_q + 3'd1;
        if (in_item_i.end_of_file) begin
          out_valid_d  = 1'b1;
          out_d        = '0;
          out_d.status = STATUS_TRUNCATED;
        end
      end else begin
        byte_pos_d = '0;
        if (rec_ctrl.marker && !rec_ctrl.error) begin
          time_offset_d = time_offset_q + OffsetStep;
        end
        if (rec_ctrl.error) begin
          error_d = 1'b1;
        end
        if (rec_ctrl.emit) begin
          out_valid_d = 1'b1;
          out_d       = rec_result;
        end
      end
    end
    // End of file clears all decode state after its own result.
    if (in_fire && in_item_i.end_of_file) begin
      byte_pos_d    = '0;
      time_offset_d = '0;
      error_d       = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q    <= '0;
      time_offset_q <= '0;
      error_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      byte_pos_q    <= byte_pos_d;
      time_offset_q <= time_offset_d;
      error_q       <= error_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers: held record bytes and the result.
  always_ff @(posedge clk_i) begin
    if (hold_byte) begin
      held_q[byte_pos_q[1:0]] <= in_item_i.data_byte;
    end
    out_q <= out_d;
  end

  // An error always leaves the byte counter at the start of a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni) error_q |-> (byte_pos_q == '0))
    else $error("error state with a partial record held");

  // The byte counter never passes the last byte of a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      byte_pos_q <= 3'(RecordBytes - 1))
    else $error("byte position out of range");

  // An event result is never pending while decoding is stopped by an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && (out_q.status == STATUS_EVENT)) |-> !error_q)
    else $error("event result pending in error state");

endmodule

// ----- rtl/core/erd_eval.sv -----
`timescale 1ns / 1ps

module erd_eval import erd_pkg::*; (
  input  logic [7:0]  x_i,
  input  logic [7:0]  y_i,
  input  logic [7:0]  b2_i,
  input  logic [7:0]  b3_i,
  input  logic [7:0]  b4_i,
  input  logic [31:0] time_offset_i,
  input  logic [7:0]  sensor_width_i,
  input  logic [7:0]  sensor_height_i,
  output rec_ctrl_t   ctrl_o,
  output out_item_t   result_o
);

  logic [TsWidth-1:0] ts;
  logic [32:0]        sum;
  logic               offset_full;
  logic               out_of_range;

  // Assemble the 23-bit timestamp and form the absolute time with carry.
  assign ts  = {b2_i[6:0], b3_i, b4_i};
  assign sum = {1'b0, time_offset_i} + {{(33 - TsWidth){1'b0}}, ts};

  // Adding one offset step would pass 2^32 - 1 exactly when the top bits are all set.
  assign offset_full  = &time_offset_i[31:TsWidth];
  assign out_of_range = (x_i >= sensor_width_i) || (y_i >= sensor_height_i) || sum[32];

  // Classify the record and build its result.
  always_comb begin
    ctrl_o   = '0;
    result_o = '0;
    result_o.status = STATUS_EVENT;
    if (y_i == MarkerY) begin
      ctrl_o.marker = 1'b1;
      if (offset_full) begin
        ctrl_o.emit     = 1'b1;
        ctrl_o.error    = 1'b1;
        result_o.status = STATUS_OFFSET_OV;
      end
    end else if (out_of_range) begin
      ctrl_o.emit     = 1'b1;
      ctrl_o.error    = 1'b1;
      result_o.status = STATUS_INVALID;
    end else begin
      ctrl_o.emit         = 1'b1;
      result_o.pos_x      = x_i;
      result_o.pos_y      = y_i;
      result_o.polarity   = b2_i[7];
      result_o.event_time = sum[31:0];
    end
  end

endmodule

// ----- dv/event_record_decoder_tb.sv -----
`timescale 1ns / 1ps

module event_record_decoder_tb;
  import erd_pkg::*;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // Block ports; every input is at a known value from time zero.
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = RegSensorWidth;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  event_record_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Bytes waiting to be sent and results the decoder still owes us.
  in_item_t  bytes_to_send[$];
  out_item_t results_due[$];

  int bytes_queued = 0;
  int bytes_accepted = 0;
  int bytes_decoded = 0;
  int settings_count = 0;
  int mismatch_count = 0;
  int status_count[4] = '{default: 0};
  bit steady = 1'b0;

  // Shadow copy of the decoder: sensor size and record assembly state.
  logic [7:0]  cols = SensorReset;
  logic [7:0]  rows = SensorReset;
  logic [2:0]  rec_pos = '0;
  logic [7:0]  rec_bytes[4] = '{default: '0};
  logic [31:0] offset = '0;
  bit          halted = 1'b0;

  function automatic void clear_decoder();
    rec_pos = '0;
    offset = '0;
    halted = 1'b0;
  endfunction

  // Append one predicted result transaction to the list of those still owed.
  function automatic void owe_result(out_item_t res);
    results_due = {results_due, res};
  endfunction

  // Work out the result, if any, that one accepted byte produces.
  function automatic void decode_byte(in_item_t it);
    out_item_t   res;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [22:0] stamp;
    res = '0;
    // After an error only the end of the file matters.
    if (halted) begin
      if (it.end_of_file) clear_decoder();
      return;
    end
    bytes_decoded++;
    // Still collecting the first four bytes of a record.
    if (rec_pos < 3'd4) begin
      rec_bytes[rec_pos[1:0]] = it.data_byte;
      rec_pos++;
      if (it.end_of_file) begin
        res.status = STATUS_TRUNCATED;
        owe_result(res);
        clear_decoder();
      end
      return;
    end
    // Fifth byte completes the record.
    rec_pos = '0;
    x = rec_bytes[0];
    y = rec_bytes[1];
    stamp = {rec_bytes[2][6:0], rec_bytes[3], it.data_byte};
    if (y == MarkerY) begin
      if (offset > 32'hFFFF_FFFF - OffsetStep) begin
        res.status = STATUS_OFFSET_OV;
        owe_result(res);
        halted = 1'b1;
      end else begin
        offset = offset + OffsetStep;
      end
    end else if (x >= cols || y >= rows || {9'd0, stamp} > 32'hFFFF_FFFF - offset) begin
      res.status = STATUS_INVALID;
      owe_result(res);
      halted = 1'b1;
    end else begin
      res.status = STATUS_EVENT;
      res.pos_x = x;
      res.pos_y = y;
      res.polarity = rec_bytes[2][7];
      res.event_time = offset + {9'd0, stamp};
      owe_result(res);
    end
    if (it.end_of_file) clear_decoder();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Driver: feeds bytes from the queue and predicts on every accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        bytes_accepted++;
        decode_byte(in_item_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (bytes_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          in_item_i <= bytes_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        status_count[out_item_o.status]++;
        if (results_due.size() == 0) begin
          report_mismatch("result with none outstanding, status",
                          32'(out_item_o.status), 32'd0);
        end else begin
          want = results_due.pop_front();
          if (out_item_o.status !== want.status)
            report_mismatch("status", 32'(out_item_o.status), 32'(want.status));
          if (out_item_o.pos_x !== want.pos_x)
            report_mismatch("pos_x", 32'(out_item_o.pos_x), 32'(want.pos_x));
          if (out_item_o.pos_y !== want.pos_y)
            report_mismatch("pos_y", 32'(out_item_o.pos_y), 32'(want.pos_y));
          if (out_item_o.polarity !== want.polarity)
            report_mismatch("polarity", 32'(out_item_o.polarity), 32'(want.polarity));
          if (out_item_o.event_time !== want.event_time)
            report_mismatch("event_time", out_item_o.event_time, want.event_time);
        end
      end
      out_ready_i <= steady || $urandom_range(0, 99) >= 33;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eof);
    in_item_t it;
    it.data_byte = b;
    it.end_of_file = eof;
    bytes_to_send = {bytes_to_send, it};
    bytes_queued++;
  endtask

  task automatic push_record(input logic [7:0] x, input logic [7:0] y, input logic [7:0] b2,
                             input logic [7:0] b3, input logic [7:0] b4, input logic eof);
    push_byte(x, 1'b0);
    push_byte(y, 1'b0);
    push_byte(b2, 1'b0);
    push_byte(b3, 1'b0);
    push_byte(b4, eof);
  endtask

  // One random file: mostly legal events, some markers and bad records,
  // and now and then a file that stops inside a record.
  task automatic push_file();
    int         n;
    int         pick;
    int         k;
    logic [7:0] x;
    logic [7:0] y;
    logic       tail;
    n = $urandom_range(1, 8);
    for (int r = 0; r < n; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)), i == k - 1);
        return;
      end
      x = 8'($urandom_range(0, 255));
      y = 8'($urandom_range(0, 255));
      if (pick < 70) begin
        if (cols != 0) x = 8'($urandom_range(0, int'(cols) - 1));
        if (rows != 0) y = 8'($urandom_range(0, int'(rows) - 1));
        if (y == MarkerY) y = y - 8'd1;
      end else if (pick < 82) begin
        y = MarkerY;
      end
      tail = (r == n - 1) && ($urandom_range(0, 3) == 0);
      push_record(x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), (r == n - 1) && !tail);
      if (tail) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)), i == k - 1);
      end
    end
  endtask

  // Hold off new bytes until every sent byte is taken and every result is back.
  task automatic wait_idle();
    while (bytes_accepted != bytes_queued || results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == RegSensorWidth) cols = val;
    else rows = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sensor sizes per phase: extremes first, zero sizes, then random ones, and last the reset size.
  logic [7:0] phase_cols[8] = '{8'd255, 8'd1, 8'd255, 8'd0, 8'd200, 8'd0, 8'd0, 8'd34};
  logic [7:0] phase_rows[8] = '{8'd255, 8'd1, 8'd1, 8'd200, 8'd0, 8'd0, 8'd0, 8'd34};

  initial begin
    int goal;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed records under the reset sensor size.
    push_record(8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    push_record(8'd33, 8'd33, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_record(8'd7, MarkerY, 8'h80, 8'h12, 8'h34, 1'b0);
    push_record(8'd5, 8'd6, 8'h01, 8'h02, 8'h03, 1'b1);
    push_record(8'd0, 8'd34, 8'h00, 8'h00, 8'h00, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'd1, 1'b0);
    push_byte(8'd2, 1'b1);
    push_byte(8'h55, 1'b1);
    settings_count = 1;

    // Step the offset up with a run of markers, then add the largest timestamp.
    for (int i = 0; i < 40; i++) begin
      push_record(8'($urandom_range(0, 255)), MarkerY, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    end
    push_record(8'd0, 8'd0, 8'h7F, 8'hFF, 8'hFF, 1'b0);
    push_record(8'd33, 8'd33, 8'h80, 8'h00, 8'h00, 1'b0);
    push_record(8'd3, MarkerY, 8'h00, 8'h00, 8'h00, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b1);

    // Random files under a series of sensor sizes; one phase runs without idling.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      if (p == 5 || p == 6) begin
        phase_cols[p] = 8'($urandom_range(1, 255));
        phase_rows[p] = 8'($urandom_range(1, 255));
      end
      write_reg(RegSensorWidth, phase_cols[p]);
      write_reg(RegSensorHeight, phase_rows[p]);
      settings_count++;
      steady = (p == 2);
      goal = bytes_decoded + ((p == 2) ? 120 : 45);
      while (bytes_decoded < goal) begin
        if (bytes_to_send.size() < 16) push_file();
        else @(posedge clk_i);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes (%0d decoded) under %0d sensor size settings.",
             bytes_accepted, bytes_decoded, settings_count);
    $display("Results: %0d events, %0d invalid, %0d offset overflow, %0d truncated.",
             status_count[STATUS_EVENT], status_count[STATUS_INVALID],
             status_count[STATUS_OFFSET_OV], status_count[STATUS_TRUNCATED]);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #2_000_000;
    $display("Timeout waiting for results.");
    $display("Verification failed");
    $finish;
  end

endmodule
